// ===== rtl/ccc_pkg.sv =====
`timescale 1ns / 1ps

package ccc_pkg;

	// Fixed field widths of the circle pair and the result.
	localparam int unsigned COORD_W = 31;
	localparam int unsigned RAD_W   = 30;
	localparam int unsigned MAG_W   = 31;
	localparam int unsigned SQ_W    = 63;
	localparam int unsigned ROOT_W  = 32;
	localparam int unsigned NORM_FRAC = 16;
	localparam int unsigned QUO_W   = NORM_FRAC + 1;
	localparam int unsigned PEN_W   = 31;
	localparam int unsigned NORM_W  = 18;
	localparam int unsigned OUT_W   = 32;

	// Number of square root steps, one result bit per step.
	localparam int unsigned SQRT_STEPS = ROOT_W;

	// Per-item data that rides beside the square root and the divider.
	typedef struct packed {
		logic                   hit;
		logic                   sx;
		logic                   sy;
		logic [MAG_W-1:0]       mx;
		logic [MAG_W-1:0]       my;
		logic [COORD_W-1:0]     ax;
		logic [COORD_W-1:0]     ay;
		logic [RAD_W-1:0]       ra;
		logic [PEN_W-1:0]       rsum;
	} side_t;

endpackage

// ===== rtl/ccc_isqrt.sv =====
`timescale 1ns / 1ps

// Pipelined integer square root, one result bit resolved in each stage.
module ccc_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [ccc_pkg::SQ_W-1:0]      in_val,
	input  ccc_pkg::side_t                in_side,
	output logic                          out_vld,
	output logic [ccc_pkg::ROOT_W-1:0]    out_root,
	output ccc_pkg::side_t                out_side
);

	localparam int unsigned N = ccc_pkg::SQRT_STEPS;

	logic [63:0]    rem_sn  [0:N];
	logic [63:0]    root_sn [0:N];
	ccc_pkg::side_t side_sn [0:N];
	logic           vld_sn  [0:N];

	assign rem_sn[0]  = {1'b0, in_val};
	assign root_sn[0] = 64'd0;
	assign side_sn[0] = in_side;
	assign vld_sn[0]  = in_vld;

	for (genvar i = 0; i < N; i++) begin : g_step
		logic [63:0] bitv;
		logic [63:0] trial;
		logic        take;

		// Trial subtraction of the running root plus the current bit.
		assign bitv  = 64'd1 << (62 - 2 * i);
		assign trial = root_sn[i] + bitv;
		assign take  = rem_sn[i] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[i+1] <= 1'b0;
			end else if (en) begin
				vld_sn[i+1] <= vld_sn[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sn[i+1]  <= take ? rem_sn[i] - trial : rem_sn[i];
				root_sn[i+1] <= take ? (root_sn[i] >> 1) + bitv : root_sn[i] >> 1;
				side_sn[i+1] <= side_sn[i];
			end
		end
	end

	assign out_vld  = vld_sn[N];
	assign out_root = root_sn[N][ccc_pkg::ROOT_W-1:0];
	assign out_side = side_sn[N];

endmodule

// ===== rtl/ccc_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider for both normal components, one quotient bit
// per stage. The dividend carries half the divisor for round to nearest.
module ccc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [ccc_pkg::ROOT_W-1:0]    in_dist,
	input  ccc_pkg::side_t                in_side,
	output logic                          out_vld,
	output logic [ccc_pkg::ROOT_W-1:0]    out_dist,
	output logic [ccc_pkg::QUO_W-1:0]     out_qx,
	output logic [ccc_pkg::QUO_W-1:0]     out_qy,
	output ccc_pkg::side_t                out_side
);

	localparam int unsigned N   = ccc_pkg::QUO_W;
	localparam int unsigned RW  = ccc_pkg::ROOT_W + N;

	logic [RW-1:0]                 remx_sn [0:N];
	logic [RW-1:0]                 remy_sn [0:N];
	logic [N-1:0]                  qx_sn   [0:N];
	logic [N-1:0]                  qy_sn   [0:N];
	logic [ccc_pkg::ROOT_W-1:0]    dist_sn [0:N];
	ccc_pkg::side_t                side_sn [0:N];
	logic                          vld_sn  [0:N];

	assign remx_sn[0] = (RW'(in_side.mx) << ccc_pkg::NORM_FRAC) + RW'(in_dist >> 1);
	assign remy_sn[0] = (RW'(in_side.my) << ccc_pkg::NORM_FRAC) + RW'(in_dist >> 1);
	assign qx_sn[0]   = '0;
	assign qy_sn[0]   = '0;
	assign dist_sn[0] = in_dist;
	assign side_sn[0] = in_side;
	assign vld_sn[0]  = in_vld;

	for (genvar j = 0; j < N; j++) begin : g_bit
		logic [RW-1:0] dvs;
		logic          tx;
		logic          ty;

		// Compare against the divisor aligned to this quotient bit.
		assign dvs = RW'(dist_sn[j]) << (N - 1 - j);
		assign tx  = remx_sn[j] >= dvs;
		assign ty  = remy_sn[j] >= dvs;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[j+1] <= 1'b0;
			end else if (en) begin
				vld_sn[j+1] <= vld_sn[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				remx_sn[j+1] <= tx ? remx_sn[j] - dvs : remx_sn[j];
				remy_sn[j+1] <= ty ? remy_sn[j] - dvs : remy_sn[j];
				qx_sn[j+1]   <= {qx_sn[j][N-2:0], tx};
				qy_sn[j+1]   <= {qy_sn[j][N-2:0], ty};
				dist_sn[j+1] <= dist_sn[j];
				side_sn[j+1] <= side_sn[j];
			end
		end
	end

	assign out_vld  = vld_sn[N];
	assign out_dist = dist_sn[N];
	assign out_qx   = qx_sn[N];
	assign out_qy   = qy_sn[N];
	assign out_side = side_sn[N];

endmodule

// ===== rtl/circle_circle_contact_unit.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       input      in_valid, in_stall   centre_a_x/y, centre_b_x/y, radius_a/b
// out      output     out_valid, out_stall contact_count, penetration, normal_x/y,
//                                          contact_x/y
//
// One circle pair is accepted per cycle unless in_stall is high. The path holds
// 54 register stages (3 front stages, 32 square root stages, 17 divider stages,
// one rim stage and the output register). The whole pipeline advances together
// and holds while a result waits under out_stall. Reset clears only the valid
// bits.
module circle_circle_contact_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [ccc_pkg::COORD_W-1:0]  centre_a_x,
	input  logic signed [ccc_pkg::COORD_W-1:0]  centre_a_y,
	input  logic signed [ccc_pkg::COORD_W-1:0]  centre_b_x,
	input  logic signed [ccc_pkg::COORD_W-1:0]  centre_b_y,
	input  logic        [ccc_pkg::RAD_W-1:0]    radius_a,
	input  logic        [ccc_pkg::RAD_W-1:0]    radius_b,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                contact_count,
	output logic        [ccc_pkg::PEN_W-1:0]    penetration,
	output logic signed [ccc_pkg::NORM_W-1:0]   normal_x,
	output logic signed [ccc_pkg::NORM_W-1:0]   normal_y,
	output logic signed [ccc_pkg::OUT_W-1:0]    contact_x,
	output logic signed [ccc_pkg::OUT_W-1:0]    contact_y
);

	localparam int unsigned MW = ccc_pkg::MAG_W;
	localparam int unsigned PW = ccc_pkg::QUO_W + ccc_pkg::RAD_W;

	logic en;

	// Everything moves unless a finished result is held by the receiver.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Stage 1: centre deltas, magnitudes and radius sum.
	logic signed [MW:0]  dx, dy;
	logic                vld_s1;
	ccc_pkg::side_t      side_s1;

	assign dx = {centre_b_x[ccc_pkg::COORD_W-1], centre_b_x}
	          - {centre_a_x[ccc_pkg::COORD_W-1], centre_a_x};
	assign dy = {centre_b_y[ccc_pkg::COORD_W-1], centre_b_y}
	          - {centre_a_y[ccc_pkg::COORD_W-1], centre_a_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.hit  <= 1'b0;
			side_s1.sx   <= dx[MW];
			side_s1.sy   <= dy[MW];
			side_s1.mx   <= dx[MW] ? MW'(-dx) : MW'(dx);
			side_s1.my   <= dy[MW] ? MW'(-dy) : MW'(dy);
			side_s1.ax   <= centre_a_x;
			side_s1.ay   <= centre_a_y;
			side_s1.ra   <= radius_a;
			side_s1.rsum <= ccc_pkg::PEN_W'(radius_a) + ccc_pkg::PEN_W'(radius_b);
		end
	end

	// Stage 2: the three squares.
	logic [2*MW-1:0]     sqx_s2, sqy_s2, sqr_s2;
	logic                vld_s2;
	ccc_pkg::side_t      side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2  <= side_s1.mx * side_s1.mx;
			sqy_s2  <= side_s1.my * side_s1.my;
			sqr_s2  <= side_s1.rsum * side_s1.rsum;
			side_s2 <= side_s1;
		end
	end

	// Stage 3: squared distance and the overlap test.
	logic [ccc_pkg::SQ_W-1:0] dsq_s3;
	logic                     vld_s3;
	ccc_pkg::side_t           side_s3;
	logic [ccc_pkg::SQ_W-1:0] dsq;
	ccc_pkg::side_t           side_hit;

	assign dsq = ccc_pkg::SQ_W'(sqx_s2) + ccc_pkg::SQ_W'(sqy_s2);

	always_comb begin
		side_hit     = side_s2;
		side_hit.hit = dsq < ccc_pkg::SQ_W'(sqr_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dsq_s3  <= dsq;
			side_s3 <= side_hit;
		end
	end

	// Distance, then the two normal quotients.
	logic                         sq_vld;
	logic [ccc_pkg::ROOT_W-1:0]   sq_root;
	ccc_pkg::side_t               sq_side;
	logic                         dv_vld;
	logic [ccc_pkg::ROOT_W-1:0]   dv_dist;
	logic [ccc_pkg::QUO_W-1:0]    dv_qx, dv_qy;
	ccc_pkg::side_t               dv_side;

	ccc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.in_val   (dsq_s3),
		.in_side  (side_s3),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	ccc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (sq_vld),
		.in_dist  (sq_root),
		.in_side  (sq_side),
		.out_vld  (dv_vld),
		.out_dist (dv_dist),
		.out_qx   (dv_qx),
		.out_qy   (dv_qy),
		.out_side (dv_side)
	);

	// Rim stage 1: normal times radius with rounding bias, and penetration.
	logic                         vld_r1;
	logic [PW-1:0]                px_r1, py_r1;
	logic [ccc_pkg::QUO_W-1:0]    qx_r1, qy_r1;
	logic                         zero_r1;
	logic [ccc_pkg::PEN_W-1:0]    pen_r1;
	ccc_pkg::side_t               side_r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_r1 <= 1'b0;
		end else if (en) begin
			vld_r1 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_r1   <= PW'(dv_qx) * PW'(dv_side.ra) + PW'(1 << (ccc_pkg::NORM_FRAC - 1));
			py_r1   <= PW'(dv_qy) * PW'(dv_side.ra) + PW'(1 << (ccc_pkg::NORM_FRAC - 1));
			qx_r1   <= dv_qx;
			qy_r1   <= dv_qy;
			zero_r1 <= dv_dist == '0;
			pen_r1  <= dv_side.rsum - ccc_pkg::PEN_W'(dv_dist);
			side_r1 <= dv_side;
		end
	end

	// Rim stage 2: signed offset from the first centre, saturated, and the
	// special cases for no overlap and coincident centres.
	logic [PW-ccc_pkg::NORM_FRAC-1:0] offx, offy;
	logic signed [ccc_pkg::OUT_W:0]   cx, cy;
	logic signed [ccc_pkg::OUT_W:0]   ax_w, ay_w, ox_w, oy_w;
	logic signed [ccc_pkg::OUT_W-1:0] cx_sat, cy_sat;
	localparam logic signed [ccc_pkg::OUT_W:0] MAX_W = (33'sd1 <<< (ccc_pkg::OUT_W - 1)) - 33'sd1;
	localparam logic signed [ccc_pkg::OUT_W:0] MIN_W = -(33'sd1 <<< (ccc_pkg::OUT_W - 1));

	assign offx = px_r1[PW-1:ccc_pkg::NORM_FRAC];
	assign offy = py_r1[PW-1:ccc_pkg::NORM_FRAC];
	assign ax_w = (ccc_pkg::OUT_W+1)'($signed(side_r1.ax));
	assign ay_w = (ccc_pkg::OUT_W+1)'($signed(side_r1.ay));
	assign ox_w = $signed((ccc_pkg::OUT_W+1)'(offx));
	assign oy_w = $signed((ccc_pkg::OUT_W+1)'(offy));
	assign cx   = side_r1.sx ? ax_w - ox_w : ax_w + ox_w;
	assign cy   = side_r1.sy ? ay_w - oy_w : ay_w + oy_w;

	always_comb begin
		cx_sat = ccc_pkg::OUT_W'(cx);
		cy_sat = ccc_pkg::OUT_W'(cy);
		if (cx > MAX_W) cx_sat = ccc_pkg::OUT_W'(MAX_W);
		if (cx < MIN_W) cx_sat = ccc_pkg::OUT_W'(MIN_W);
		if (cy > MAX_W) cy_sat = ccc_pkg::OUT_W'(MAX_W);
		if (cy < MIN_W) cy_sat = ccc_pkg::OUT_W'(MIN_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_r1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!side_r1.hit) begin
				contact_count <= 1'b0;
				penetration   <= '0;
				normal_x      <= '0;
				normal_y      <= '0;
				contact_x     <= '0;
				contact_y     <= '0;
			end else if (zero_r1) begin
				contact_count <= 1'b1;
				penetration   <= ccc_pkg::PEN_W'(side_r1.ra);
				normal_x      <= ccc_pkg::NORM_W'(1 << ccc_pkg::NORM_FRAC);
				normal_y      <= '0;
				contact_x     <= ccc_pkg::OUT_W'($signed(side_r1.ax));
				contact_y     <= ccc_pkg::OUT_W'($signed(side_r1.ay));
			end else begin
				contact_count <= 1'b1;
				penetration   <= pen_r1;
				normal_x      <= side_r1.sx ? -$signed(ccc_pkg::NORM_W'(qx_r1))
				                            :  $signed(ccc_pkg::NORM_W'(qx_r1));
				normal_y      <= side_r1.sy ? -$signed(ccc_pkg::NORM_W'(qy_r1))
				                            :  $signed(ccc_pkg::NORM_W'(qy_r1));
				contact_x     <= cx_sat;
				contact_y     <= cy_sat;
			end
		end
	end

endmodule
